// File: rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the facility assignment cost checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int FAC_DEPTH  = 64;
    localparam int FAC_IDX_W  = 6;
    localparam int COUNT_W    = 7;
    localparam int CAP_W      = 16;
    localparam int COST_IN_W  = 20;
    localparam int COST_W     = 40;
    localparam int CAPSUM_W   = 22;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    localparam logic [COUNT_W-1:0]  FAC_LIMIT   = COUNT_W'(FAC_DEPTH);
    localparam logic [COST_W-1:0]   COST_MAX    = {COST_W{1'b1}};
    localparam logic [CAPSUM_W-1:0] CAPSUM_MAX  = {CAPSUM_W{1'b1}};

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_BEGIN    = 2'd0;
    localparam opcode_t OP_FACILITY = 2'd1;
    localparam opcode_t OP_CUSTOMER = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_FACILITY_COUNT = 1'b0;
    localparam cfg_index_t CFG_TOTAL_DEMAND   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } fcc_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } fcc_cmd_t;

    typedef struct packed {
        logic result_item;
        logic out_blocked;
    } fcc_status_t;

endpackage

// File: rtl/facility_assignment_cost_checker.sv
// Results: a final customer item's result is loaded into the result register
// from the execute state, which holds only while an earlier result still
// waits on the master side. Items: one at a time; a new item is taken only in
// idle, after the registered capacity table read and its write-back in execute.
// Reset: synchronous active-low aresetn clears the accumulators, config and
// handshake state; the capacity table is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// facility_assignment_cost_checker
// Cost and feasibility scoring of one capacitated facility location solution.
// ----------------------------------------------------------------------------
module facility_assignment_cost_checker
    import fcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // facility_index, is_open, capacity, open_cost, assigned_facility,
    // demand, assign_cost, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // total_cost, feasible, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fcc_cmd_t    cmd;
    fcc_status_t status;

    assign cfg_ready = 1'b1;

    fcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fcc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: rtl/fcc_ctrl.sv
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer: takes one item, runs its table update, hands off the result.
// ----------------------------------------------------------------------------
module fcc_ctrl
    import fcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  fcc_status_t status,
    output fcc_cmd_t    cmd
);

    fcc_state_t state_reg;
    fcc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold a result item while a previous result still waits for its transfer
                if (!(status.result_item && status.out_blocked)) begin
                    cmd.execute  = 1'b1;
                    cmd.load_out = status.result_item;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/fcc_datapath.sv
// ----------------------------------------------------------------------------
// fcc_datapath
// Item registers, remaining-capacity table, accumulators and result register.
// ----------------------------------------------------------------------------
module fcc_datapath
    import fcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fcc_cmd_t              cmd,
    output fcc_status_t           status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  opcode_t               s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [COUNT_W-1:0]  fac_count_reg;
    logic [CAPSUM_W-1:0] total_demand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fac_count_reg    <= FAC_LIMIT;
            total_demand_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FACILITY_COUNT: fac_count_reg    <= cfg_data[COUNT_W-1:0];
                CFG_TOTAL_DEMAND:   total_demand_reg <= cfg_data[CAPSUM_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    opcode_t               opcode_reg;
    logic                  last_reg;
    logic [FAC_IDX_W-1:0]  fidx_reg;
    logic                  is_open_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [COST_IN_W-1:0]  ocost_reg;
    logic [FAC_IDX_W-1:0]  afac_reg;
    logic [CAP_W-1:0]      demand_reg;
    logic [COST_IN_W-1:0]  acost_reg;

    logic [FAC_IDX_W-1:0]  s_afac;
    assign s_afac = s_tdata[48:43];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            opcode_reg  <= s_tuser;
            last_reg    <= s_tlast;
            fidx_reg    <= s_tdata[5:0];
            is_open_reg <= s_tdata[6];
            cap_reg     <= s_tdata[22:7];
            ocost_reg   <= s_tdata[42:23];
            afac_reg    <= s_afac;
            demand_reg  <= s_tdata[64:49];
            acost_reg   <= s_tdata[84:65];
        end
    end

    // remaining-capacity table, read registered at capture
    logic [CAP_W-1:0] cap_mem [FAC_DEPTH];
    logic [CAP_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [FAC_IDX_W-1:0] wr_addr;
    logic [CAP_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= cap_mem[s_afac];
        end
        if (wr_en) begin
            cap_mem[wr_addr] <= wr_data;
        end
    end

    // execute
    logic [COUNT_W-1:0]  used_count;
    logic                fidx_ok;
    logic                afac_ok;
    logic [CAP_W-1:0]    fac_cap;
    logic                short_cap;
    logic [COST_IN_W-1:0] cost_add;
    logic [COST_W:0]     cost_sum;
    logic [CAPSUM_W:0]   capsum_sum;

    logic [COST_W-1:0]   cost_reg;
    logic [COST_W-1:0]   cost_next;
    logic [CAPSUM_W-1:0] capsum_reg;
    logic [CAPSUM_W-1:0] capsum_next;
    logic                ovf_reg;
    logic                ovf_next;

    assign used_count = (fac_count_reg > FAC_LIMIT) ? FAC_LIMIT : fac_count_reg;
    assign fidx_ok    = {1'b0, fidx_reg} < used_count;
    assign afac_ok    = {1'b0, afac_reg} < used_count;
    assign fac_cap    = is_open_reg ? cap_reg : '0;
    assign short_cap  = demand_reg > rd_data_reg;
    assign cost_sum   = {1'b0, cost_reg} + {{(COST_W-COST_IN_W+1){1'b0}}, cost_add};
    assign capsum_sum = {1'b0, capsum_reg} + {{(CAPSUM_W-CAP_W+1){1'b0}}, fac_cap};

    always_comb begin
        cost_add    = '0;
        wr_en       = 1'b0;
        wr_addr     = afac_reg;
        wr_data     = rd_data_reg - demand_reg;
        cost_next   = cost_reg;
        capsum_next = capsum_reg;
        ovf_next    = ovf_reg;
        if (cmd.execute) begin
            unique case (opcode_reg)
                OP_BEGIN: begin
                    cost_next   = '0;
                    capsum_next = '0;
                    ovf_next    = 1'b0;
                end
                OP_FACILITY: begin
                    if (fidx_ok) begin
                        wr_en       = 1'b1;
                        wr_addr     = fidx_reg;
                        wr_data     = fac_cap;
                        capsum_next = capsum_sum[CAPSUM_W] ? CAPSUM_MAX
                                                           : capsum_sum[CAPSUM_W-1:0];
                        if (is_open_reg) begin
                            cost_add = ocost_reg;
                        end
                    end
                end
                OP_CUSTOMER: begin
                    cost_add = acost_reg;
                    if (afac_ok) begin
                        wr_en = 1'b1;
                        if (short_cap) begin
                            wr_data  = '0;
                            ovf_next = 1'b1;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                default: ;
            endcase
            if (opcode_reg != OP_BEGIN) begin
                cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg   <= '0;
            capsum_reg <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            cost_reg   <= cost_next;
            capsum_reg <= capsum_next;
            ovf_reg    <= ovf_next;
        end
    end

    // result register
    logic                  m_valid_reg;
    logic [COST_W-1:0]     m_cost_reg;
    logic                  m_feasible_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_cost_reg     <= cost_next;
            m_feasible_reg <= !ovf_next && (capsum_reg >= total_demand_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-COST_W-1){1'b0}}, m_feasible_reg, m_cost_reg};

    assign status.result_item = (opcode_reg == OP_CUSTOMER) && last_reg;
    assign status.out_blocked = m_valid_reg && !m_tready;

endmodule

// File: rtl/fcc_checker.sv
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks on the cost checker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fcc_checker
    import fcc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic s_xfer;
    logic result_item;
    assign s_xfer      = s_tvalid && s_tready;
    assign result_item = (s_tuser == OP_CUSTOMER) && s_tlast;

    // a pending result holds until its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("input taken while an item is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && result_item && !m_tvalid |=> ##1 m_tvalid)
        else $error("final customer gave no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !result_item && !m_tvalid |=> ##1 !m_tvalid)
        else $error("result from an item that gives none");

endmodule

bind facility_assignment_cost_checker fcc_checker u_fcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_facility_assignment_cost_checker.sv
// ----------------------------------------------------------------------------
// tb_facility_assignment_cost_checker
// Self-checking bench for the facility assignment cost checker. A short table
// of hand-picked items (extremes, closed and stale facilities, ignored codes,
// overflow of the capacity table) runs first. Random evaluations follow under
// several register settings. Both stream sides idle at random and the result
// side is held off once for a long stretch. Each result is compared with a
// scoring model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_facility_assignment_cost_checker;
    import fcc_pkg::*;

    localparam opcode_t OP_UNUSED = 2'd3;

    typedef struct {
        opcode_t           op;
        logic [5:0]        fidx;
        logic              open;
        logic [15:0]       cap;
        logic [19:0]       ocost;
        logic [5:0]        afac;
        logic [15:0]       dem;
        logic [19:0]       acost;
        logic              last;
    } fac_item_t;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              feas;
    } score_t;

    typedef struct {
        fac_item_t         it;
        bit                typed;
        logic [COST_W-1:0] cost;
        logic              feas;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    facility_assignment_cost_checker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // scoring state mirrored in the bench
    logic [CAP_W-1:0]    fac_remaining [FAC_DEPTH];
    bit                  fac_written   [FAC_DEPTH];
    logic [COST_W-1:0]   cost_acc      = '0;
    logic [CAPSUM_W-1:0] capsum_acc    = '0;
    logic                overflow_flag = 1'b0;
    logic [COUNT_W-1:0]  cfg_fac_count = FAC_LIMIT;
    logic [CAPSUM_W-1:0] cfg_total_dem = '0;

    score_t   pending_scores[$];
    dir_row_t dir_rows[$];
    int       fail_count = 0;
    int       items_sent = 0;
    bit       calm       = 1'b0;
    bit       hold_req   = 1'b0;
    int       hold_cnt   = 0;
    bit       hold_taken = 1'b0;
    score_t   oldest;

    function automatic int used_count();
        return (cfg_fac_count > FAC_LIMIT) ? FAC_DEPTH : int'(cfg_fac_count);
    endfunction

    function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W-1:0] acc,
                                                   input logic [COST_IN_W-1:0] amt);
        logic [COST_W:0] s;
        s = {1'b0, acc} + (COST_W+1)'(amt);
        return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
    endfunction

    task automatic score_item(input fac_item_t it, output bit has,
                              output logic [COST_W-1:0] c, output logic f);
        logic [CAPSUM_W:0] ssum;
        logic [CAP_W-1:0]  cap;
        logic [CAP_W-1:0]  rem;
        int u;
        has = 1'b0;
        c = '0;
        f = 1'b0;
        u = used_count();
        case (it.op)
            OP_BEGIN: begin
                cost_acc = '0;
                capsum_acc = '0;
                overflow_flag = 1'b0;
            end
            OP_FACILITY: begin
                if (int'(it.fidx) < u) begin
                    cap = it.open ? it.cap : '0;
                    fac_remaining[it.fidx] = cap;
                    fac_written[it.fidx] = 1'b1;
                    ssum = {1'b0, capsum_acc} + (CAPSUM_W+1)'(cap);
                    capsum_acc = (ssum > {1'b0, CAPSUM_MAX}) ? CAPSUM_MAX : ssum[CAPSUM_W-1:0];
                    if (it.open)
                        cost_acc = sat_cost(cost_acc, it.ocost);
                end
            end
            OP_CUSTOMER: begin
                cost_acc = sat_cost(cost_acc, it.acost);
                if (int'(it.afac) < u) begin
                    rem = fac_remaining[it.afac];
                    if (it.dem > rem) begin
                        overflow_flag = 1'b1;
                        fac_remaining[it.afac] = '0;
                    end else begin
                        fac_remaining[it.afac] = rem - it.dem;
                    end
                end else begin
                    overflow_flag = 1'b1;
                end
                if (it.last) begin
                    has = 1'b1;
                    c = cost_acc;
                    f = !overflow_flag && (capsum_acc >= cfg_total_dem);
                end
            end
            default: ;
        endcase
    endtask

    function automatic fac_item_t mk_item(input opcode_t op, input int fidx, input bit open,
                                          input int cap, input int ocost, input int afac,
                                          input int dem, input int acost, input bit last);
        fac_item_t it;
        it.op = op;
        it.fidx = 6'(fidx);
        it.open = open;
        it.cap = 16'(cap);
        it.ocost = 20'(ocost);
        it.afac = 6'(afac);
        it.dem = 16'(dem);
        it.acost = 20'(acost);
        it.last = last;
        return it;
    endfunction

    function automatic fac_item_t rand_item();
        fac_item_t it;
        it.op = opcode_t'($urandom_range(3));
        it.fidx = 6'($urandom);
        it.open = 1'($urandom);
        it.cap = 16'($urandom);
        it.ocost = ($urandom_range(15) == 0) ? 20'hFFFFF : 20'($urandom);
        it.afac = 6'($urandom);
        it.dem = 16'($urandom);
        it.acost = ($urandom_range(15) == 0) ? 20'hFFFFF : 20'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    // never name an in-range entry that has not been written since reset, unless all are in range and none is written
    function automatic logic [5:0] pick_afac();
        int u;
        int a;
        int k;
        u = used_count();
        if (u < FAC_DEPTH && (u == 0 || $urandom_range(7) == 0))
            return 6'(u + $urandom_range(FAC_DEPTH - 1 - u));
        for (k = 0; k < 32; k++) begin
            a = $urandom_range(FAC_DEPTH - 1);
            if (a >= u || fac_written[a])
                return 6'(a);
        end
        for (k = 0; k < u; k++)
            if (fac_written[k])
                return 6'(k);
        return 6'(u);
    endfunction

    function automatic logic [15:0] pick_demand();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r < 3)
            return 16'($urandom);
        else
            return 16'($urandom_range(2000));
    endfunction

    task automatic send_item(input fac_item_t it, input bit typed,
                             input logic [COST_W-1:0] tc, input logic tf);
        bit has;
        logic [COST_W-1:0] c;
        logic f;
        score_t sc;
        if (!calm)
            while ($urandom_range(99) < 11) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.acost, it.dem, it.afac, it.ocost, it.cap, it.open, it.fidx};
        s_tuser  <= it.op;
        s_tlast  <= it.last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        score_item(it, has, c, f);
        if (has) begin
            sc.cost = typed ? tc : c;
            sc.feas = typed ? tf : f;
            pending_scores.push_back(sc);
        end
    endtask

    task automatic send(input fac_item_t it);
        send_item(it, 1'b0, '0, 1'b0);
    endtask

    task automatic add_row(input fac_item_t it, input bit typed,
                           input logic [COST_W-1:0] c, input logic f);
        dir_row_t r;
        r.it = it;
        r.typed = typed;
        r.cost = c;
        r.feas = f;
        dir_rows.push_back(r);
    endtask

    // leaves the block idle: input dropped and every expected result taken
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_scores.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == CFG_FACILITY_COUNT)
            cfg_fac_count = val[COUNT_W-1:0];
        else
            cfg_total_dem = val;
    endtask

    task automatic run_eval();
        fac_item_t it;
        int nf;
        int nc;
        int u;
        int i;
        u = used_count();
        it = rand_item();
        it.op = OP_BEGIN;
        send(it);
        nf = $urandom_range(1, 8);
        repeat (nf) begin
            it = rand_item();
            it.op = OP_FACILITY;
            if (u > 0 && $urandom_range(9) != 0)
                it.fidx = 6'($urandom_range(u - 1));
            it.open = ($urandom_range(3) != 0);
            if ($urandom_range(7) == 0)
                it.cap = 16'hFFFF;
            send(it);
        end
        nc = $urandom_range(1, 6);
        for (i = 0; i < nc; i++) begin
            it = rand_item();
            it.op = OP_CUSTOMER;
            it.afac = pick_afac();
            it.dem = pick_demand();
            it.last = (i == nc - 1) || ($urandom_range(9) == 0);
            send(it);
        end
    endtask

    task automatic run_phase(input int count, input int demand, input int n_items,
                             input bit quiet, input bit stress);
        fac_item_t it;
        int k;
        int stop_at;
        wait_drain();
        write_reg(CFG_FACILITY_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_TOTAL_DEMAND, CFG_DATA_W'(demand));
        cfg_valid <= 1'b0;
        calm <= quiet;
        @(posedge aclk);
        if (stress) begin
            // capacity sum runs past its 22-bit ceiling
            send(mk_item(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0));
            for (k = 0; k < 66; k++)
                send(mk_item(OP_FACILITY, k % FAC_DEPTH, 1, 'hFFFF, 0, 0, 0, 0, 0));
            send(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 0, 0, 0, 1));
            // result items keep coming while the receiver holds off, so input stalls behind the held result
            hold_req <= 1'b1;
            for (k = 0; k < 24; k++) begin
                it = rand_item();
                it.op = OP_CUSTOMER;
                it.afac = pick_afac();
                it.dem = '0;
                it.last = 1'b1;
                send(it);
            end
            wait_drain();
        end
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                it = rand_item();
                if (it.op == OP_CUSTOMER)
                    it.afac = pick_afac();
                send(it);
            end else begin
                run_eval();
            end
        end
    endtask

    // result side: checking and back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                $error("unexpected result: total_cost %h feasible %b",
                       m_tdata[COST_W-1:0], m_tdata[COST_W]);
                fail_count++;
            end else begin
                oldest = pending_scores.pop_front();
                if (m_tdata[COST_W-1:0] !== oldest.cost) begin
                    $error("total_cost: expected %h, got %h", oldest.cost, m_tdata[COST_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[COST_W] !== oldest.feas) begin
                    $error("feasible: expected %b, got %b", oldest.feas, m_tdata[COST_W]);
                    fail_count++;
                end
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt = 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    initial begin
        #400000;
        $display("tb_facility_assignment_cost_checker: done, errors");
        $finish;
    end

    initial begin
        foreach (fac_written[i]) begin
            fac_written[i] = 1'b0;
            fac_remaining[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 64 facilities, zero total demand
        add_row(mk_item(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0, 0);
        add_row(mk_item(OP_FACILITY, 0, 1, 'hFFFF, 'hFFFFF, 0, 0, 0, 0), 0, '0, 0);
        add_row(mk_item(OP_FACILITY, 63, 1, 0, 0, 0, 0, 0, 0), 0, '0, 0);
        // closed facility: no cost, zero capacity stored
        add_row(mk_item(OP_FACILITY, 5, 0, 1234, 999, 0, 0, 0, 0), 0, '0, 0);
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 0, 'hFFFF, 'hFFFFF, 1), 1, 40'd2097150, 1);
        // demand past what is left
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 0, 1, 0, 1), 1, 40'd2097150, 0);
        add_row(mk_item(OP_UNUSED, 7, 1, 5, 5, 3, 3, 3, 1), 0, '0, 0);
        add_row(mk_item(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0, 0);
        add_row(mk_item(OP_FACILITY, 1, 1, 100, 5, 0, 0, 0, 1), 0, '0, 0);
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 5, 0, 7, 1), 0, '0, 0);
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 63, 1, 3, 0), 0, '0, 0);
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 1, 100, 0, 1), 0, '0, 0);
        // no begin: accumulation carries on after the last customer
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 1, 0, 1, 1), 0, '0, 0);
        add_row(mk_item(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0, 0);
        // stale entry from the previous evaluation
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 0, 0, 'hFFFFF, 1), 1, 40'd1048575, 1);
        add_row(mk_item(OP_FACILITY, 63, 1, 'hFFFF, 0, 0, 0, 0, 0), 0, '0, 0);
        add_row(mk_item(OP_FACILITY, 63, 1, 'hFFFF, 0, 0, 0, 0, 0), 0, '0, 0);
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 63, 'hFFFF, 0, 1), 0, '0, 0);
        add_row(mk_item(OP_FACILITY, 63, 0, 'hFFFF, 'hFFFFF, 0, 0, 0, 0), 0, '0, 0);
        add_row(mk_item(OP_CUSTOMER, 0, 0, 0, 0, 63, 0, 0, 1), 0, '0, 0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].cost, dir_rows[i].feas);

        run_phase(1,   0,                       180, 1'b0, 1'b0);
        run_phase(64,  4194303,                 200, 1'b0, 1'b1);
        run_phase(17,  $urandom_range(200000),  200, 1'b1, 1'b0);
        run_phase(0,   0,                       100, 1'b0, 1'b0);
        run_phase(100, $urandom_range(50000),   200, 1'b0, 1'b0);
        run_phase(64,  $urandom_range(4194303), 200, 1'b0, 1'b0);
        run_phase(46,  1000,                    200, 1'b0, 1'b0);

        wait_drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_facility_assignment_cost_checker: done, clean");
        else
            $display("tb_facility_assignment_cost_checker: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/fcc_pkg.sv
rtl/fcc_ctrl.sv
rtl/fcc_datapath.sv
rtl/facility_assignment_cost_checker.sv
rtl/fcc_checker.sv
tb/tb_facility_assignment_cost_checker.sv
